>>> rtl/core/perspective_vertex_project_unit_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the vertex projection unit
// Shared property forms, clocked on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef PERSPECTIVE_VERTEX_PROJECT_UNIT_DEFINES_SVH
`define PERSPECTIVE_VERTEX_PROJECT_UNIT_DEFINES_SVH

// Same-cycle implication
`define PVP_ASSERT_IMP(lbl, ant, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (cons)) \
        else $error(msg);

// Implication after a fixed number of cycles
`define PVP_ASSERT_DLY(lbl, ant, n, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> ##n (cons)) \
        else $error(msg);

`endif

>>> rtl/core/pvp_pkg.sv
// ----------------------------------------------------------------------------
// pvp_pkg
// Widths, register map, payload types and helpers for the projection unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pvp_pkg;

    localparam int COEF_FRAC_BITS = 8;
    localparam int COEF_W   = 16;
    localparam int COORD_W  = 24;
    localparam int DEPTH_W  = 16;
    localparam int ROW_W    = 64;
    localparam int PROD1_W  = COEF_W + COORD_W;          // coef * object coord
    localparam int EYE_W    = 42;
    localparam int PROD2_W  = COEF_W + EYE_W;            // coef * eye coord
    localparam int CLIP_W   = 60;
    localparam int N_W      = CLIP_W + 1;                // c + w
    localparam int W_W      = EYE_W + COEF_FRAC_BITS;    // w = -ez << frac
    localparam int UD_W     = W_W + 1;                   // |2w|
    localparam int T_FRAC   = 16;
    localparam int DIV_Q_W  = 41;                        // quotient bits, cap at 2^41 and above
    localparam int DIV_SHIFT = DIV_Q_W - T_FRAC;
    localparam int T_W      = DIV_Q_W + 1;
    localparam int P_W      = T_W + 17;                  // size * t
    localparam int V_W      = P_W - 8 + 1;

    localparam int PRE_STAGES  = 5;
    localparam int DIV_STAGES  = DIV_Q_W + 2;
    localparam int POST_STAGES = 2;
    localparam int LATENCY     = PRE_STAGES + DIV_STAGES + POST_STAGES;

    // Register map
    localparam int NREG   = 7;
    localparam int CFG_AW = 6;
    localparam int IDX_W  = 3;
    localparam logic [IDX_W-1:0] REG_MV_X    = 3'd0;
    localparam logic [IDX_W-1:0] REG_MV_Y    = 3'd1;
    localparam logic [IDX_W-1:0] REG_MV_Z    = 3'd2;
    localparam logic [IDX_W-1:0] REG_PROJ_X  = 3'd3;
    localparam logic [IDX_W-1:0] REG_PROJ_Y  = 3'd4;
    localparam logic [IDX_W-1:0] REG_PROJ_Z  = 3'd5;
    localparam logic [IDX_W-1:0] REG_VIEW    = 3'd6;

    localparam logic [ROW_W-1:0] ROW_X_RST = 64'h0000_0000_0000_0100;
    localparam logic [ROW_W-1:0] ROW_Y_RST = 64'h0000_0000_0100_0000;
    localparam logic [ROW_W-1:0] ROW_Z_RST = 64'h0000_0100_0000_0000;
    localparam logic [ROW_W-1:0] VIEW_RST  = 64'h0;

    localparam logic signed [V_W-1:0] WIN_MAX = V_W'(64'sd8388607);
    localparam logic signed [V_W-1:0] WIN_MIN = V_W'(-64'sd8388608);

    typedef struct packed {
        logic signed [COORD_W-1:0] obj_x;
        logic signed [COORD_W-1:0] obj_y;
        logic signed [COORD_W-1:0] obj_z;
    } obj_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] win_x;
        logic signed [COORD_W-1:0] win_y;
        logic        [DEPTH_W-1:0] win_depth;
        logic                      proj_ok;
    } result_t;

    function automatic logic signed [COEF_W-1:0] coef_of(input logic [ROW_W-1:0] row,
                                                         input logic [1:0] k);
        return row[COEF_W*k +: COEF_W];
    endfunction

endpackage

>>> rtl/core/pvp_div.sv
// ----------------------------------------------------------------------------
// pvp_div
// Pipelined restoring divider: min(num * 2^16 / den, sat), one bit a stage, negated if neg.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pvp_div
    import pvp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  in_tag,
    input  logic [N_W-1:0]        num,
    input  logic [UD_W-1:0]       den,
    input  logic                  neg,
    output logic                  out_valid,
    output logic                  out_tag,
    output logic signed [T_W-1:0] quot
);

    logic                 valid_reg [0:DIV_Q_W];
    logic                 tag_reg   [0:DIV_Q_W];
    logic                 sat_reg   [0:DIV_Q_W];
    logic                 neg_reg   [0:DIV_Q_W];
    logic [UD_W-1:0]      den_reg   [0:DIV_Q_W];
    logic [UD_W-1:0]      rem_reg   [0:DIV_Q_W];
    logic [DIV_Q_W-1:0]   low_reg   [0:DIV_Q_W];
    logic [DIV_Q_W-1:0]   quo_reg   [0:DIV_Q_W];

    logic                 ovf;
    logic [DIV_Q_W-1:0]   mag;
    logic                 out_valid_reg;
    logic                 out_tag_reg;
    logic signed [T_W-1:0] quot_reg;

    // quotient would exceed 41 bits
    assign ovf = (num >> DIV_SHIFT) >= N_W'(den);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg[0] <= 1'b0;
        end
        else
        begin
            valid_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        tag_reg[0] <= in_tag;
        sat_reg[0] <= ovf;
        neg_reg[0] <= neg;
        den_reg[0] <= den;
        rem_reg[0] <= UD_W'(num >> DIV_SHIFT);
        low_reg[0] <= {num[DIV_SHIFT-1:0], {T_FRAC{1'b0}}};
        quo_reg[0] <= '0;
    end

    for (genvar k = 1; k <= DIV_Q_W; k++)
    begin : g_step
        logic [UD_W:0]   trial;
        logic            ge;
        logic [UD_W:0]   diff;

        assign trial = {rem_reg[k-1], low_reg[k-1][DIV_Q_W-1]};
        assign ge    = trial >= {1'b0, den_reg[k-1]};
        assign diff  = trial - {1'b0, den_reg[k-1]};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k] <= 1'b0;
            end
            else
            begin
                valid_reg[k] <= valid_reg[k-1];
            end
        end

        always_ff @(posedge clk)
        begin
            tag_reg[k] <= tag_reg[k-1];
            sat_reg[k] <= sat_reg[k-1];
            neg_reg[k] <= neg_reg[k-1];
            den_reg[k] <= den_reg[k-1];
            rem_reg[k] <= ge ? diff[UD_W-1:0] : trial[UD_W-1:0];
            low_reg[k] <= {low_reg[k-1][DIV_Q_W-2:0], 1'b0};
            quo_reg[k] <= {quo_reg[k-1][DIV_Q_W-2:0], ge};
        end
    end

    assign mag = sat_reg[DIV_Q_W] ? {DIV_Q_W{1'b1}} : quo_reg[DIV_Q_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= valid_reg[DIV_Q_W];
        end
    end

    always_ff @(posedge clk)
    begin
        out_tag_reg <= tag_reg[DIV_Q_W];
        quot_reg    <= neg_reg[DIV_Q_W] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    end

    assign out_valid = out_valid_reg;
    assign out_tag   = out_tag_reg;
    assign quot      = quot_reg;

endmodule

>>> rtl/core/perspective_vertex_project_unit.sv
// ----------------------------------------------------------------------------
// perspective_vertex_project_unit
// Object-space vertex to window coordinates, fixed-point, fully pipelined.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: drive obj with start high; a request is taken at every
//   rising edge where start is high (busy is tied low, so one vertex a cycle).
//   Result channel: done is high for exactly one cycle with the result on
//   result; the receiver cannot hold results off, and nothing here ever needs
//   it to, as each stage advances every cycle.
//   Throughput: one request per cycle. The path from request to result
//   runs through the quotient divider, 41 restoring stages plus entry and
//   exit registers, with five transform stages ahead of it and two
//   viewport stages behind.
//   Config: APB, seven 64-bit registers at 8*i (modelview rows 0..2,
//   projection rows 0..2, viewport); write only while no request in flight.
//   Reset: pipeline valids clear, registers return to identity rows and a
//   zero viewport; no clearing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module perspective_vertex_project_unit
    import pvp_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    // request channel
    input  logic               start,
    output logic               busy,
    input  obj_t               obj,
    // result channel
    output logic               done,
    output result_t            result,
    // config port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [CFG_AW-1:0]  paddr,
    input  logic [ROW_W-1:0]   pwdata,
    output logic [ROW_W-1:0]   prdata,
    output logic               pready
);

    // ---------------------------------------------------------------- config
    logic [ROW_W-1:0] cfg_reg [0:NREG-1];
    logic [IDX_W-1:0] cfg_idx;
    logic             cfg_wr;

    assign pready  = 1'b1;
    assign busy    = 1'b0;
    assign cfg_idx = paddr[CFG_AW-1:3];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg[REG_MV_X]   <= ROW_X_RST;
            cfg_reg[REG_MV_Y]   <= ROW_Y_RST;
            cfg_reg[REG_MV_Z]   <= ROW_Z_RST;
            cfg_reg[REG_PROJ_X] <= ROW_X_RST;
            cfg_reg[REG_PROJ_Y] <= ROW_Y_RST;
            cfg_reg[REG_PROJ_Z] <= ROW_Z_RST;
            cfg_reg[REG_VIEW]   <= VIEW_RST;
        end
        else if (cfg_wr && (int'(cfg_idx) < NREG))
        begin
            cfg_reg[cfg_idx] <= pwdata;
        end
    end

    assign prdata = (int'(cfg_idx) < NREG) ? cfg_reg[cfg_idx] : '0;

    // ------------------------------------------------ stage 1: modelview products
    logic signed [COORD_W-1:0] obj_c [0:2];
    logic signed [PROD1_W-1:0] prod1_reg [0:2][0:2];
    logic signed [COEF_W-1:0]  tr1_reg [0:2];
    logic                      v1_reg;

    assign obj_c[0] = obj.obj_x;
    assign obj_c[1] = obj.obj_y;
    assign obj_c[2] = obj.obj_z;

    always_ff @(posedge clk)
    begin
        for (int r = 0; r < 3; r++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                prod1_reg[r][k] <= PROD1_W'(coef_of(cfg_reg[REG_MV_X + IDX_W'(r)], 2'(k)))
                                   * PROD1_W'(obj_c[k]);
            end
            tr1_reg[r] <= coef_of(cfg_reg[REG_MV_X + IDX_W'(r)], 2'd3);
        end
    end

    // ------------------------------------------------ stage 2: eye coordinates
    logic signed [EYE_W-1:0] eye_reg [0:2];
    logic                    v2_reg;

    always_ff @(posedge clk)
    begin
        for (int r = 0; r < 3; r++)
        begin
            eye_reg[r] <= EYE_W'(prod1_reg[r][0]) + EYE_W'(prod1_reg[r][1])
                        + EYE_W'(prod1_reg[r][2]) + (EYE_W'(tr1_reg[r]) <<< 8);
        end
    end

    // ------------------------------------------------ stage 3: projection products
    logic signed [PROD2_W-1:0] prod2_reg [0:2][0:2];
    logic signed [COEF_W-1:0]  tr3_reg [0:2];
    logic signed [EYE_W-1:0]   ez3_reg;
    logic                      v3_reg;

    always_ff @(posedge clk)
    begin
        for (int r = 0; r < 3; r++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                prod2_reg[r][k] <= PROD2_W'(coef_of(cfg_reg[REG_PROJ_X + IDX_W'(r)], 2'(k)))
                                   * PROD2_W'(eye_reg[k]);
            end
            tr3_reg[r] <= coef_of(cfg_reg[REG_PROJ_X + IDX_W'(r)], 2'd3);
        end
        ez3_reg <= eye_reg[2];
    end

    // ------------------------------------------------ stage 4: clip coords and w
    logic signed [CLIP_W-1:0] clip_reg [0:2];
    logic signed [W_W-1:0]    w_reg;
    logic                     ok4_reg;
    logic                     v4_reg;

    always_ff @(posedge clk)
    begin
        for (int r = 0; r < 3; r++)
        begin
            clip_reg[r] <= CLIP_W'(prod2_reg[r][0]) + CLIP_W'(prod2_reg[r][1])
                         + CLIP_W'(prod2_reg[r][2])
                         + (CLIP_W'(tr3_reg[r]) <<< (COEF_FRAC_BITS + 8));
        end
        w_reg   <= -(W_W'(ez3_reg) <<< COEF_FRAC_BITS);
        ok4_reg <= (ez3_reg != '0);
    end

    // ------------------------------------------------ stage 5: (c + w) / 2w operands
    logic signed [N_W-1:0] n_sum [0:2];
    logic [N_W-1:0]        un_reg [0:2];
    logic                  neg_reg [0:2];
    logic [UD_W-1:0]       ud_reg;
    logic                  ok5_reg;
    logic                  v5_reg;

    for (genvar r = 0; r < 3; r++)
    begin : g_num
        assign n_sum[r] = N_W'(clip_reg[r]) + N_W'(w_reg);
    end

    always_ff @(posedge clk)
    begin
        for (int r = 0; r < 3; r++)
        begin
            un_reg[r]  <= n_sum[r][N_W-1] ? N_W'(-n_sum[r]) : N_W'(n_sum[r]);
            neg_reg[r] <= n_sum[r][N_W-1] ^ w_reg[W_W-1];
        end
        ud_reg  <= {(w_reg[W_W-1] ? W_W'(-w_reg) : W_W'(w_reg)), 1'b0};
        ok5_reg <= ok4_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= start && !busy;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    // ------------------------------------------------ divider lanes
    logic signed [T_W-1:0] t_q [0:2];
    logic                  dv;
    logic                  d_ok;

    for (genvar r = 0; r < 3; r++)
    begin : g_div
        if (r == 0)
        begin : g_lead
            pvp_div u_div (
                .clk       (clk),
                .rst_n     (rst_n),
                .in_valid  (v5_reg),
                .in_tag    (ok5_reg),
                .num       (un_reg[r]),
                .den       (ud_reg),
                .neg       (neg_reg[r]),
                .out_valid (dv),
                .out_tag   (d_ok),
                .quot      (t_q[r])
            );
        end
        else
        begin : g_side
            pvp_div u_div (
                .clk       (clk),
                .rst_n     (rst_n),
                .in_valid  (v5_reg),
                .in_tag    (ok5_reg),
                .num       (un_reg[r]),
                .den       (ud_reg),
                .neg       (neg_reg[r]),
                .out_valid (),
                .out_tag   (),
                .quot      (t_q[r])
            );
        end
    end

    // ------------------------------------------------ viewport stage 1: size * t
    logic signed [P_W-1:0]     px_reg, py_reg;
    logic [DEPTH_W-1:0]        dep_reg;
    logic [15:0]               ox_reg, oy_reg;
    logic                      okw_reg;
    logic                      vw_reg;
    logic [ROW_W-1:0]          vr;

    assign vr = cfg_reg[REG_VIEW];

    always_ff @(posedge clk)
    begin
        px_reg  <= P_W'($signed({1'b0, vr[47:32]})) * P_W'(t_q[0]);
        py_reg  <= P_W'($signed({1'b0, vr[63:48]})) * P_W'(t_q[1]);
        ox_reg  <= vr[15:0];
        oy_reg  <= vr[31:16];
        okw_reg <= d_ok;
        if (t_q[2][T_W-1])
        begin
            dep_reg <= '0;
        end
        else if (t_q[2] > T_W'(65535))
        begin
            dep_reg <= '1;
        end
        else
        begin
            dep_reg <= t_q[2][DEPTH_W-1:0];
        end
    end

    // ------------------------------------------------ viewport stage 2: origin, saturate
    logic signed [V_W-1:0] vx, vy;
    logic signed [COORD_W-1:0] sx, sy;
    result_t               res_reg;
    logic                  done_reg;

    assign vx = V_W'($signed({1'b0, ox_reg, 8'b0})) + V_W'(px_reg >>> 8);
    assign vy = V_W'($signed({1'b0, oy_reg, 8'b0})) + V_W'(py_reg >>> 8);
    assign sx = (vx > WIN_MAX) ? COORD_W'(WIN_MAX) :
                (vx < WIN_MIN) ? COORD_W'(WIN_MIN) : vx[COORD_W-1:0];
    assign sy = (vy > WIN_MAX) ? COORD_W'(WIN_MAX) :
                (vy < WIN_MIN) ? COORD_W'(WIN_MIN) : vy[COORD_W-1:0];

    always_ff @(posedge clk)
    begin
        res_reg.win_x     <= okw_reg ? sx : '0;
        res_reg.win_y     <= okw_reg ? sy : '0;
        res_reg.win_depth <= okw_reg ? dep_reg : '0;
        res_reg.proj_ok   <= okw_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vw_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            vw_reg   <= dv;
            done_reg <= vw_reg;
        end
    end

    assign done   = done_reg;
    assign result = res_reg;

endmodule

>>> rtl/core/pvp_check.sv
// ----------------------------------------------------------------------------
// pvp_check
// Port-level checks on the projection unit, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "perspective_vertex_project_unit_defines.svh"

module pvp_check
    import pvp_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    input  logic    busy,
    input  logic    done,
    input  result_t result
);

    `PVP_ASSERT_IMP(a_never_busy, 1'b1, !busy, "busy raised")
    `PVP_ASSERT_DLY(a_fixed_latency, start && !busy, LATENCY, done, "request result missing")
    `PVP_ASSERT_IMP(a_no_spurious, done, $past(start, LATENCY), "result without request")
    `PVP_ASSERT_IMP(a_zero_on_fail, done && !result.proj_ok, result.win_x == '0 && result.win_y == '0 && result.win_depth == '0, "nonzero result with zero w")

endmodule

bind perspective_vertex_project_unit pvp_check u_pvp_check (.*);
